// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the oscillator rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/lts_pkg.sv =====
// constants, types and lookup tables of the log tuned sine oscillator
// no dependencies; tables are built by constant functions at elaboration
`default_nettype none

package lts_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int OUTPUT_BITS    = 12;
    localparam int KNOB_BITS      = 12;
    localparam int KNOB_DEPTH     = 1 << KNOB_BITS;
    localparam int SINE_DEPTH     = 1 << SINE_ADDR_BITS;

    localparam logic [63:0] SAMPLE_RATE_HZ = 64'd10000;
    localparam logic [63:0] RESET_FREQ_HZ  = 64'd1000;
    localparam logic [63:0] LOG2_500_Q40   = 64'd9857984073117;
    localparam logic [63:0] LN2_Q30        = 64'd744261118;
    localparam logic [63:0] TWO_PI_Q48     = 64'd1768559438007110;
    localparam logic [63:0] ONE_Q30        = 64'd1073741824;
    localparam logic [63:0] KNOB_FULL      = 64'd4095;
    localparam logic [63:0] FREQ_MAX       = 64'd8191;
    localparam logic [63:0] OUT_MAX        = (64'd1 << OUTPUT_BITS) - 64'd1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KNOB = 1'b1;

    typedef logic [PHASE_BITS-1:0]  t_phase;
    typedef logic [KNOB_BITS-1:0]   t_knob;
    typedef logic [OUTPUT_BITS-1:0] t_code;
    typedef t_phase t_inc_rom [KNOB_DEPTH];
    typedef t_code  t_sine_rom [SINE_DEPTH];

    // tone frequency in hz, 10 * 500^(k/4095), exponential by series
    function automatic logic [63:0] knob_to_freq(input logic [63:0] k);
        logic [63:0] e;
        logic [63:0] ip;
        logic [63:0] u;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] v;
        e   = (k * LOG2_500_Q40 + (KNOB_FULL >> 1)) / KNOB_FULL;
        ip  = e >> 40;
        u   = e & ((64'd1 << 40) - 64'd1);
        y   = ((u >> 10) * LN2_Q30) >> 30;
        t   = ONE_Q30;
        sum = ONE_Q30;
        for (int n = 1; n <= 13; n++) begin
            t   = ((t * y) >> 30) / 64'(n);
            sum = sum + t;
        end
        if (ip > 64'd8) begin
            ip = 64'd8;
        end
        v = (64'd10 * sum) << ip;
        v = (v + (ONE_Q30 >> 1)) >> 30;
        if (v > FREQ_MAX) begin
            v = FREQ_MAX;
        end
        return v;
    endfunction

    function automatic t_phase freq_to_inc(input logic [63:0] f);
        logic [63:0] inc;
        inc = ((f << PHASE_BITS) + (SAMPLE_RATE_HZ >> 1)) / SAMPLE_RATE_HZ;
        return inc[PHASE_BITS-1:0];
    endfunction

    // quarter-wave folded taylor series, offset to unsigned
    function automatic t_code sine_code(input logic [63:0] idx);
        logic [63:0] half;
        logic [63:0] quarter;
        logic [63:0] j;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] mag;
        logic [63:0] val;
        logic [63:0] code;
        longint      sum;
        logic        neg;
        half    = 64'd1 << (SINE_ADDR_BITS - 1);
        quarter = half >> 1;
        j       = idx & (half - 64'd1);
        neg     = (idx & half) != 64'd0;
        if (j > quarter) begin
            j = half - j;
        end
        if (j == quarter) begin
            mag = ONE_Q30;
        end else if (j == 64'd0) begin
            mag = 64'd0;
        end else begin
            x   = (j * TWO_PI_Q48 + (64'd1 << (SINE_ADDR_BITS + 17)))
                  >> (SINE_ADDR_BITS + 18);
            t   = x;
            sum = longint'(x);
            for (int m = 3; m <= 15; m += 2) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / 64'(m * (m - 1));
                if (((m >> 1) & 1) != 0) begin
                    sum = sum - longint'(t);
                end else begin
                    sum = sum + longint'(t);
                end
            end
            if (sum < 0) begin
                mag = 64'd0;
            end else if (64'(sum) > ONE_Q30) begin
                mag = ONE_Q30;
            end else begin
                mag = 64'(sum);
            end
        end
        val  = neg ? (ONE_Q30 - mag) : (ONE_Q30 + mag);
        code = (val * OUT_MAX) >> 31;
        if (code > OUT_MAX) begin
            code = OUT_MAX;
        end
        return code[OUTPUT_BITS-1:0];
    endfunction

    function automatic t_inc_rom build_inc_rom();
        t_inc_rom rom;
        for (int i = 0; i < KNOB_DEPTH; i++) begin
            rom[i] = freq_to_inc(knob_to_freq(64'(i)));
        end
        return rom;
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            rom[i] = sine_code(64'(i));
        end
        return rom;
    endfunction

    localparam t_phase    RESET_INC = freq_to_inc(RESET_FREQ_HZ);
    localparam t_inc_rom  INC_ROM   = build_inc_rom();
    localparam t_sine_rom SINE_ROM  = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/core/lts_ifs.sv =====
// valid/ready channel interfaces for the oscillator input and result
// depends on lts_pkg
`default_nettype none

interface lts_in_if import lts_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  command;
    t_knob knob_value;

    modport source (output valid, output command, output knob_value, input ready);
    modport sink   (input valid, input command, input knob_value, output ready);
endinterface

interface lts_out_if import lts_pkg::*; ();
    logic  valid;
    logic  ready;
    t_code dac_code;

    modport source (output valid, output dac_code, input ready);
    modport sink   (input valid, input dac_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/log_tuned_sine_oscillator.sv =====
// a tick transaction waits in the s0 register, then its sample is registered into the output register
// throughput: one transaction per cycle while the result channel takes samples; a tick stalls in s0 otherwise
// a knob transaction gives no sample; its rom read lands before the next tick
// reset (synchronous, active low) clears phase, sets the tone to 1000 hz
// depends on lts_pkg, lts_ifs and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module log_tuned_sine_oscillator import lts_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    lts_in_if.sink        i_in,
    lts_out_if.source     o_out
);

    logic   r_s0_valid;
    logic   r_s0_cmd;
    t_phase r_knob_inc;
    t_phase r_phase_inc;
    t_phase r_phase;
    logic   r_out_valid;
    t_code  r_out_code;

    logic   n_s0_valid;
    logic   n_out_valid;
    t_phase n_phase;
    t_phase n_phase_inc;

    logic   in_take;
    logic   out_free;
    logic   s0_go;
    logic   s0_tick;
    logic   s0_knob;
    logic [SINE_ADDR_BITS-1:0] sine_addr;

    assign out_free  = !r_out_valid || o_out.ready;
    assign s0_go     = r_s0_valid && ((r_s0_cmd == CMD_KNOB) || out_free);
    assign s0_tick   = s0_go && (r_s0_cmd == CMD_TICK);
    assign s0_knob   = s0_go && (r_s0_cmd == CMD_KNOB);
    assign in_take   = i_in.valid && i_in.ready;
    assign sine_addr = r_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];

    assign i_in.ready     = !r_s0_valid || s0_go;
    assign o_out.valid    = r_out_valid;
    assign o_out.dac_code = r_out_code;

    always_comb begin
        n_s0_valid = r_s0_valid;
        if (in_take) begin
            n_s0_valid = 1'b1;
        end else if (s0_go) begin
            n_s0_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s0_tick) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        n_phase     = s0_tick ? (r_phase + r_phase_inc) : r_phase;
        n_phase_inc = s0_knob ? r_knob_inc : r_phase_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_phase_inc <= RESET_INC;
        end else begin
            r_s0_valid  <= n_s0_valid;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_phase_inc <= n_phase_inc;
        end
    end

    // frequency rom, read at acceptance
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s0_cmd   <= i_in.command;
            r_knob_inc <= INC_ROM[i_in.knob_value];
        end
    end

    // sine rom, read with the phase before it advances
    always_ff @(posedge i_clk) begin
        if (s0_tick) begin
            r_out_code <= SINE_ROM[sine_addr];
        end
    end

    `ASSERT_CLK(a_tick_gives_sample, i_clk, i_rst_n, s0_tick |=> r_out_valid, "tick lost")
    `ASSERT_CLK(a_knob_sets_inc, i_clk, i_rst_n, s0_knob |=> (r_phase_inc == $past(r_knob_inc)), "knob increment not taken")
    `ASSERT_CLK(a_phase_only_on_tick, i_clk, i_rst_n, !s0_tick |=> $stable(r_phase), "phase moved without tick")
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, s0_tick && r_out_valid && !o_out.ready, "pending sample overwritten")

endmodule

`default_nettype wire
